// ===== sv/cia_pkg.sv =====
`timescale 1ns / 1ps

package cia_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DATA_W);

    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_NEG  = 3'd5
    } op_t;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ADD_OVF = 3'd1;
    localparam logic [2:0] ST_MUL_OVF = 3'd2;
    localparam logic [2:0] ST_DIV_Z   = 3'd3;
    localparam logic [2:0] ST_NEG_OVF = 3'd4;

    // control from the sequencer to the shift/add engine
    typedef struct packed {
        logic start;
        logic div;
    } eng_ctl_t;

endpackage

// ===== sv/cia_addsub.sv =====
`timescale 1ns / 1ps

module cia_addsub (
    input  logic [cia_pkg::DATA_W:0]   x,
    input  logic [cia_pkg::DATA_W:0]   y,
    input  logic                       sub,
    output logic [cia_pkg::DATA_W+1:0] sum
);

    logic [cia_pkg::DATA_W+1:0] y_ext;

    assign y_ext = {1'b0, y} ^ {(cia_pkg::DATA_W + 2){sub}};
    assign sum   = {1'b0, x} + y_ext + {{(cia_pkg::DATA_W + 1){1'b0}}, sub};

endmodule

// ===== sv/cia_engine.sv =====
`timescale 1ns / 1ps

module cia_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cia_pkg::eng_ctl_t             ctl,
    input  logic [cia_pkg::DATA_W-1:0]    a_mag,
    input  logic [cia_pkg::DATA_W-1:0]    b_mag,
    output logic                          done,
    output logic [2*cia_pkg::DATA_W-1:0]  result
);

    localparam int W = cia_pkg::DATA_W;

    logic                      busy_reg;
    logic                      done_reg;
    logic                      div_reg;
    logic [cia_pkg::CNT_W-1:0] cnt_reg;
    logic [W-1:0]              m_reg;
    logic [W-1:0]              hi_reg;
    logic [W-1:0]              lo_reg;
    logic [W-1:0]              hi_next;
    logic [W-1:0]              lo_next;

    logic [W:0]   add_x;
    logic [W:0]   add_y;
    logic [W+1:0] add_sum;

    // multiply: add multiplicand when multiplier lsb set, shift right
    // divide: trial subtract of divisor from shifted remainder
    assign add_x = div_reg ? {hi_reg, lo_reg[W-1]} : {1'b0, hi_reg};
    assign add_y = (div_reg || lo_reg[0]) ? {1'b0, m_reg} : '0;

    cia_addsub u_addsub (
        .x   (add_x),
        .y   (add_y),
        .sub (div_reg),
        .sum (add_sum)
    );

    always_comb
    begin
        if (div_reg)
        begin
            hi_next = add_sum[W+1] ? add_x[W-1:0] : add_sum[W-1:0];
            lo_next = {lo_reg[W-2:0], ~add_sum[W+1]};
        end
        else
        begin
            hi_next = add_sum[W:1];
            lo_next = {add_sum[0], lo_reg[W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                div_reg  <= ctl.div;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == {cia_pkg::CNT_W{1'b1}})
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            m_reg  <= b_mag;
            hi_reg <= '0;
            lo_reg <= a_mag;
        end
        else if (busy_reg)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign done   = done_reg;
    assign result = {hi_reg, lo_reg};

endmodule

// ===== sv/checked_int32_accumulator.sv =====
`timescale 1ns / 1ps

// Signed 32-bit accumulator with overflow checks. Each request beat carries an
// operation (load, add, subtract, multiply, divide toward zero, negate) and an
// operand; each yields one response beat with the new accumulator and a status
// code. A flagged operation leaves the accumulator unchanged. Load, add,
// subtract, negate, unused codes and divide by zero go from S_IDLE straight to
// S_DONE; multiply and divide pass through S_RUN, for the 32-step shift/add
// loop of the single 33-bit adder that serves both. One item is in
// work at a time; a finished response waits in the output register while the
// next request is taken.
module checked_int32_accumulator (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [2:0]            req_type,
    input  logic signed [31:0]    operand,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic signed [31:0]    acc_value,
    output logic [2:0]            status
);

    localparam int W = cia_pkg::DATA_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [W-1:0]      acc_reg;
    logic [W-1:0]      acc_next;
    logic [2:0]        code_reg;
    logic [2:0]        code_next;
    logic              neg_reg;
    logic              neg_next;
    logic              div_reg;
    logic              div_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [W-1:0]      acc_value_reg;
    logic [W-1:0]      acc_value_next;
    logic [2:0]        status_reg;
    logic [2:0]        status_next;

    cia_pkg::eng_ctl_t eng_ctl;
    logic              eng_done;
    logic [2*W-1:0]    eng_result;

    logic [W-1:0]      b;
    logic [W:0]        sum_add;
    logic [W:0]        sum_sub;
    logic [W-1:0]      a_neg;
    logic [W-1:0]      b_neg;
    logic [W-1:0]      a_mag;
    logic [W-1:0]      b_mag;
    logic [W-1:0]      r_neg;
    logic              mul_fits;
    cia_pkg::op_t      op;

    assign b       = operand;
    assign op      = cia_pkg::op_t'(req_type);
    assign sum_add = {acc_reg[W-1], acc_reg} + {b[W-1], b};
    assign sum_sub = {acc_reg[W-1], acc_reg} - {b[W-1], b};
    assign a_neg   = '0 - acc_reg;
    assign b_neg   = '0 - b;
    assign a_mag   = acc_reg[W-1] ? a_neg : acc_reg;
    assign b_mag   = b[W-1] ? b_neg : b;
    assign r_neg   = '0 - eng_result[W-1:0];

    // product magnitude must fit 2^31 - 1, or 2^31 when negative
    assign mul_fits = (eng_result[2*W-1:W] == '0) &&
                      (!eng_result[W-1] || (neg_reg && eng_result[W-2:0] == '0));

    cia_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (eng_ctl),
        .a_mag  (a_mag),
        .b_mag  (b_mag),
        .done   (eng_done),
        .result (eng_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        code_next      = code_reg;
        neg_next       = neg_reg;
        div_next       = div_reg;
        rsp_valid_next = rsp_valid_reg;
        acc_value_next = acc_value_reg;
        status_next    = status_reg;
        eng_ctl        = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    code_next  = cia_pkg::ST_OK;
                    state_next = S_DONE;
                    unique case (op)
                        cia_pkg::OP_LOAD:
                        begin
                            acc_next = b;
                        end
                        cia_pkg::OP_ADD:
                        begin
                            if (sum_add[W] != sum_add[W-1])
                                code_next = cia_pkg::ST_ADD_OVF;
                            else
                                acc_next = sum_add[W-1:0];
                        end
                        cia_pkg::OP_SUB:
                        begin
                            if (sum_sub[W] != sum_sub[W-1])
                                code_next = cia_pkg::ST_ADD_OVF;
                            else
                                acc_next = sum_sub[W-1:0];
                        end
                        cia_pkg::OP_MUL:
                        begin
                            eng_ctl.start = 1'b1;
                            eng_ctl.div   = 1'b0;
                            div_next      = 1'b0;
                            neg_next      = acc_reg[W-1] ^ b[W-1];
                            state_next    = S_RUN;
                        end
                        cia_pkg::OP_DIV:
                        begin
                            if (b == '0)
                            begin
                                code_next = cia_pkg::ST_DIV_Z;
                            end
                            else
                            begin
                                eng_ctl.start = 1'b1;
                                eng_ctl.div   = 1'b1;
                                div_next      = 1'b1;
                                neg_next      = acc_reg[W-1] ^ b[W-1];
                                state_next    = S_RUN;
                            end
                        end
                        cia_pkg::OP_NEG:
                        begin
                            if (acc_reg == {1'b1, {(W - 1){1'b0}}})
                                code_next = cia_pkg::ST_NEG_OVF;
                            else
                                acc_next = a_neg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                if (eng_done)
                begin
                    state_next = S_DONE;
                    if (div_reg)
                    begin
                        if (!neg_reg && eng_result[W-1])
                            code_next = cia_pkg::ST_NEG_OVF;
                        else
                            acc_next = neg_reg ? r_neg : eng_result[W-1:0];
                    end
                    else
                    begin
                        if (!mul_fits)
                            code_next = cia_pkg::ST_MUL_OVF;
                        else
                            acc_next = neg_reg ? r_neg : eng_result[W-1:0];
                    end
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    acc_value_next = acc_reg;
                    status_next    = code_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            code_reg      <= cia_pkg::ST_OK;
            neg_reg       <= 1'b0;
            div_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            acc_value_reg <= '0;
            status_reg    <= cia_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            code_reg      <= code_next;
            neg_reg       <= neg_next;
            div_reg       <= div_next;
            rsp_valid_reg <= rsp_valid_next;
            acc_value_reg <= acc_value_next;
            status_reg    <= status_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign acc_value = acc_value_reg;
    assign status    = status_reg;

endmodule

// ===== sv/cia_checker.sv =====
`timescale 1ns / 1ps

module cia_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic [2:0]         req_type,
    input logic signed [31:0] operand,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic signed [31:0] acc_value,
    input logic [2:0]         status
);

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(acc_value) && $stable(status))
        else $error("response beat changed under stall");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == cia_pkg::ST_OK || status == cia_pkg::ST_ADD_OVF ||
                       status == cia_pkg::ST_MUL_OVF || status == cia_pkg::ST_DIV_Z ||
                       status == cia_pkg::ST_NEG_OVF))
        else $error("undefined status code");

    // one item at a time: busy right after a request beat
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while item in work");

    // a load taken while no response is pending succeeds with the loaded value
    a_load_value: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_type == cia_pkg::OP_LOAD && !rsp_valid |=>
        ##1 rsp_valid && status == cia_pkg::ST_OK && acc_value == $past(operand, 2))
        else $error("load result mismatch");

endmodule

bind checked_int32_accumulator cia_checker u_cia_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .operand   (operand),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .acc_value (acc_value),
    .status    (status)
);
